// File: sv/mtfe_pkg.sv
// mtfe_pkg: shared types, constants and font table of the text framebuffer engine
// no dependencies
package mtfe_pkg;
   localparam int ScreenWidth  = 128;
   localparam int ScreenHeight = 64;
   localparam int PageCount    = ScreenHeight / 8;
   localparam int TextCols     = ScreenWidth / 5;
   localparam int StoreBytes   = PageCount * ScreenWidth;
   localparam int AddrBits     = $clog2(StoreBytes);
   localparam int ColBits      = $clog2(ScreenWidth);
   localparam int PageBits     = $clog2(PageCount);

   typedef logic [AddrBits-1:0] addr_type;
   typedef logic [7:0]          byte_type;

   localparam logic [2:0] ACT_TEXT  = 3'd0;
   localparam logic [2:0] ACT_PIXEL = 3'd1;
   localparam logic [2:0] ACT_FILL  = 3'd2;
   localparam logic [2:0] ACT_READ  = 3'd3;
   localparam logic [2:0] ACT_FLUSH = 3'd4;

   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LAST  = 8'h7F;

   // memory port request from the sequencer
   typedef struct packed {
      logic     we;
      addr_type addr;
      byte_type wdata;
   } mem_req_type;

   // font column lookup, glyph index 0..95 and column 0..4
   function automatic byte_type glyph_col(input logic [6:0] g, input logic [2:0] c);
      logic [39:0] row;
      unique case (g)
         7'd0: row=40'h0000000000; 7'd1: row=40'h00004F0000; 7'd2: row=40'h0007000700;
         7'd3: row=40'h147F147F14; 7'd4: row=40'h242A7F2A12; 7'd5: row=40'h2313086462;
         7'd6: row=40'h3649552250; 7'd7: row=40'h0005030000; 7'd8: row=40'h001C224100;
         7'd9: row=40'h0041221C00; 7'd10: row=40'h14083E0814; 7'd11: row=40'h08083E0808;
         7'd12: row=40'h0050300000; 7'd13: row=40'h0808080808; 7'd14: row=40'h0060600000;
         7'd15: row=40'h2010080402; 7'd16: row=40'h3E5149453E; 7'd17: row=40'h00427F4000;
         7'd18: row=40'h4261514946; 7'd19: row=40'h2141454B31; 7'd20: row=40'h1814127F10;
         7'd21: row=40'h2745454539; 7'd22: row=40'h3C4A494930; 7'd23: row=40'h0301710907;
         7'd24: row=40'h3649494936; 7'd25: row=40'h064949291E; 7'd26: row=40'h0036360000;
         7'd27: row=40'h0056360000; 7'd28: row=40'h0814224100; 7'd29: row=40'h1414141414;
         7'd30: row=40'h0041221408; 7'd31: row=40'h0201510906; 7'd32: row=40'h324979413E;
         7'd33: row=40'h7E1111117E; 7'd34: row=40'h7F49494936; 7'd35: row=40'h3E41414122;
         7'd36: row=40'h7F4141221C; 7'd37: row=40'h7F49494941; 7'd38: row=40'h7F09090901;
         7'd39: row=40'h3E4149497A; 7'd40: row=40'h7F0808087F; 7'd41: row=40'h00417F4100;
         7'd42: row=40'h2040413F01; 7'd43: row=40'h7F08142241; 7'd44: row=40'h7F40404040;
         7'd45: row=40'h7F020C027F; 7'd46: row=40'h7F0408107F; 7'd47: row=40'h3E4141413E;
         7'd48: row=40'h7F09090906; 7'd49: row=40'h3E4151215E; 7'd50: row=40'h7F09192946;
         7'd51: row=40'h4649494931; 7'd52: row=40'h01017F0101; 7'd53: row=40'h3F4040403F;
         7'd54: row=40'h1F2040201F; 7'd55: row=40'h3F4038403F; 7'd56: row=40'h6314081463;
         7'd57: row=40'h0708700807; 7'd58: row=40'h6151494543; 7'd59: row=40'h7F41410000;
         7'd60: row=40'h15167C1615; 7'd61: row=40'h0041417F00; 7'd62: row=40'h0402010204;
         7'd63: row=40'h4040404040; 7'd64: row=40'h0001020400; 7'd65: row=40'h2054545478;
         7'd66: row=40'h7F48444438; 7'd67: row=40'h3844444420; 7'd68: row=40'h384444487F;
         7'd69: row=40'h3854545418; 7'd70: row=40'h087E090102; 7'd71: row=40'h0C5252523E;
         7'd72: row=40'h7F08040478; 7'd73: row=40'h00447D4000; 7'd74: row=40'h2040443D00;
         7'd75: row=40'h7F10284400; 7'd76: row=40'h00417F4000; 7'd77: row=40'h7C04180478;
         7'd78: row=40'h7C08040478; 7'd79: row=40'h3844444438; 7'd80: row=40'h7C14141408;
         7'd81: row=40'h081414187C; 7'd82: row=40'h7C08040408; 7'd83: row=40'h4854545420;
         7'd84: row=40'h043F444020; 7'd85: row=40'h3C4040207C; 7'd86: row=40'h1C2040201C;
         7'd87: row=40'h3C4038403C; 7'd88: row=40'h4428102844; 7'd89: row=40'h0C5050503C;
         7'd90: row=40'h4464544C44; 7'd91: row=40'h0008364100; 7'd92: row=40'h00007F0000;
         7'd93: row=40'h0041360800; 7'd94: row=40'h08082A1C08; 7'd95: row=40'h081C2A0808;
         default: row=40'h0;
      endcase
      unique case (c)
         3'd0: glyph_col = row[39:32];
         3'd1: glyph_col = row[31:24];
         3'd2: glyph_col = row[23:16];
         3'd3: glyph_col = row[15:8];
         default: glyph_col = row[7:0];
      endcase
   endfunction
endpackage

// File: sv/mtfe_store.sv
// mtfe_store: frame byte memory, one port, registered read
// depends on mtfe_pkg
module mtfe_store (
   input  logic                 clock,
   input  mtfe_pkg::mem_req_type req,
   output mtfe_pkg::byte_type    rdata
);
   import mtfe_pkg::*;

   byte_type mem [StoreBytes];

   // write or read, read data registered for the cycle after
   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      rdata <= mem[req.addr];
   end
endmodule

// File: sv/mono_text_framebuffer_engine_core.sv
// mono_text_framebuffer_engine_core: page framebuffer with 5x7 text terminal, uses mtfe_pkg
// flush, cr, lf and unused codes go straight to the result, pixel draw and read first read the byte,
// a glyph writes five columns, fill and scroll (after lf or a glyph) sweep the single store port
// one item at a time, next item taken the cycle after its result
// reset: clearing pass writes zero to all 1024 bytes, busy high
// results are shown one cycle with rsp_valid; the receiver cannot stall
module mono_text_framebuffer_engine_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_action,
   input  logic [7:0] req_char_code,
   input  logic [6:0] req_x_pos,
   input  logic [5:0] req_y_pos,
   input  logic       req_color,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_pixel_bit,
   output logic [4:0] rsp_cursor_col,
   output logic [2:0] rsp_cursor_row,
   output logic [6:0] rsp_dirty_col_start,
   output logic [7:0] rsp_dirty_width,
   output logic [2:0] rsp_dirty_page_start,
   output logic [3:0] rsp_dirty_pages,
   output logic       rsp_scrolled,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_invert_text
);
   import mtfe_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_GLYPH  = 4'd2;
   localparam logic [3:0] S_PXRD   = 4'd3;
   localparam logic [3:0] S_PXWAIT = 4'd4;
   localparam logic [3:0] S_PXWR   = 4'd5;
   localparam logic [3:0] S_RDWAIT = 4'd6;
   localparam logic [3:0] S_RDOUT  = 4'd7;
   localparam logic [3:0] S_FILL   = 4'd8;
   localparam logic [3:0] S_SCRRD  = 4'd9;
   localparam logic [3:0] S_SCRWR  = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [AddrBits:0] cnt_ff, cnt_in;
   logic [4:0]  ccol_ff, ccol_in;
   logic [2:0]  cpage_ff, cpage_in;
   logic [6:0]  dcol_ff, dcol_in;
   logic [7:0]  dw_ff, dw_in;
   logic [2:0]  dpg_ff, dpg_in;
   logic [3:0]  dh_ff, dh_in;
   logic        inv_ff, inv_in;
   logic        scr_ff, scr_in;
   logic [7:0]  rb_ff, rb_in;
   logic        rbit_ff, rbit_in;
   logic        vld_ff, vld_in;
   // latched item
   logic [2:0]  act_ff, act_in;
   logic [6:0]  gidx_ff, gidx_in;
   logic [6:0]  x_ff, x_in;
   logic [5:0]  y_ff, y_in;
   logic        col_ff, col_in;

   mem_req_type mreq;
   byte_type    rdata;

   mtfe_store u_store (.clock(clock), .req(mreq), .rdata(rdata));

   // dirty growth of one point, applied to a given rectangle
   function automatic logic [21:0] grow(input logic [21:0] r, input logic [6:0] c,
                                        input logic [2:0] p);
      logic [6:0] sc; logic [7:0] w; logic [2:0] sp; logic [3:0] h;
      {sc, w, sp, h} = r;
      if (c < sc) begin
         w = w + 8'(sc - c); sc = c;
      end else if ({1'b0, c} >= 8'({1'b0, sc}) + w) begin
         w = 8'(c - sc) + 8'd1;
      end
      if (p < sp) begin
         h = h + 4'(sp - p); sp = p;
      end else if ({1'b0, p} >= 4'({1'b0, sp}) + h) begin
         h = 4'(p - sp) + 4'd1;
      end
      grow = {sc, w, sp, h};
   endfunction

   logic [6:0] base_col;
   logic [7:0] gbyte;
   logic [21:0] r0, r1, r2, r3;
   logic [6:0]  px_col;
   logic        in_range;
   logic [4:0]  ccol_next;

   assign busy      = (state_ff != S_IDLE) || vld_ff;
   assign csr_ready = 1'b1;
   assign base_col  = 7'(ccol_ff * 5);
   assign gbyte     = glyph_col(gidx_ff, cnt_ff[2:0]) ^ {8{inv_ff}};
   assign in_range  = ({1'b0, req_x_pos} < 8'(ScreenWidth))
                      && ({1'b0, req_y_pos} < 7'(ScreenHeight));
   assign px_col    = x_ff;
   assign ccol_next = ccol_ff + 5'd1;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff;
      ccol_in = ccol_ff; cpage_in = cpage_ff;
      dcol_in = dcol_ff; dw_in = dw_ff; dpg_in = dpg_ff; dh_in = dh_ff;
      inv_in = inv_ff; scr_in = scr_ff; rb_in = rb_ff; rbit_in = rbit_ff;
      vld_in = 1'b0;
      act_in = act_ff; gidx_in = gidx_ff; x_in = x_ff; y_in = y_ff; col_in = col_ff;
      mreq = '{we: 1'b0, addr: '0, wdata: '0};
      r0 = '0; r1 = '0; r2 = '0; r3 = '0;
      if (csr_valid) inv_in = csr_invert_text;
      unique case (state_ff)
         // clearing pass after reset
         S_CLEAR: begin
            mreq = '{we: 1'b1, addr: addr_type'(cnt_ff), wdata: 8'h00};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AddrBits+1)'(StoreBytes - 1)) state_in = S_IDLE;
         end
         // take an item
         S_IDLE: begin
            if (start && !busy) begin
               act_in = req_action; x_in = req_x_pos; y_in = req_y_pos;
               col_in = req_color; cnt_in = '0; scr_in = 1'b0;
               rb_in = '0; rbit_in = 1'b0;
               if (req_char_code < CHAR_SPACE || req_char_code > CHAR_LAST)
                  gidx_in = 7'd0;
               else
                  gidx_in = 7'(req_char_code - CHAR_SPACE);
               unique case (req_action)
                  ACT_TEXT: begin
                     if (req_char_code == CHAR_CR) begin
                        state_in = S_DONE;
                     end else if (req_char_code == CHAR_LF) begin
                        r0 = grow({dcol_ff, dw_ff, dpg_ff, dh_ff}, base_col, cpage_ff);
                        {dcol_in, dw_in, dpg_in, dh_in} = r0;
                        ccol_in = '0;
                        if (cpage_ff == 3'(PageCount - 1)) state_in = S_SCRRD;
                        else begin
                           cpage_in = cpage_ff + 3'd1; state_in = S_DONE;
                        end
                     end else begin
                        state_in = S_GLYPH;
                     end
                  end
                  ACT_PIXEL: state_in = in_range ? S_PXRD : S_DONE;
                  ACT_FILL: state_in = S_FILL;
                  ACT_READ: state_in = in_range ? S_PXRD : S_DONE;
                  ACT_FLUSH: begin
                     dcol_in = '0; dw_in = '0; dpg_in = '0; dh_in = '0;
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         // write five glyph columns, cursor and dirty update with the last
         S_GLYPH: begin
            mreq = '{we: 1'b1, wdata: gbyte,
                     addr: addr_type'({cpage_ff, 7'(base_col + 7'(cnt_ff[2:0]))})};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[2:0] == 3'd4) begin
               r0 = grow({dcol_ff, dw_ff, dpg_ff, dh_ff}, base_col, cpage_ff);
               r1 = grow(r0, 7'(base_col + 7'd4), cpage_ff);
               r2 = grow(r1, base_col, cpage_ff);
               r3 = grow(r2, 7'(ScreenWidth - 1), cpage_ff);
               if ({27'd0, ccol_next} >= TextCols) begin
                  {dcol_in, dw_in, dpg_in, dh_in} = r3;
                  ccol_in = '0;
                  if (cpage_ff == 3'(PageCount - 1)) begin
                     state_in = S_SCRRD; cnt_in = '0;
                  end else begin
                     cpage_in = cpage_ff + 3'd1; state_in = S_DONE;
                  end
               end else begin
                  {dcol_in, dw_in, dpg_in, dh_in} = r1;
                  ccol_in = ccol_next; state_in = S_DONE;
               end
            end
         end
         // read the addressed byte
         S_PXRD: begin
            mreq.addr = addr_type'({y_ff[5:3], x_ff});
            state_in = (act_ff == ACT_READ) ? S_RDWAIT : S_PXWAIT;
         end
         // keep the address on the port so the read data stays valid
         S_PXWAIT: begin
            mreq.addr = addr_type'({y_ff[5:3], x_ff});
            state_in = S_PXWR;
         end
         S_RDWAIT: begin
            mreq.addr = addr_type'({y_ff[5:3], x_ff});
            state_in = S_RDOUT;
         end
         // modify the pixel and write back
         S_PXWR: begin
            mreq.we = 1'b1;
            mreq.addr = addr_type'({y_ff[5:3], x_ff});
            mreq.wdata = col_ff ? (rdata | (8'd1 << y_ff[2:0]))
                                : (rdata & ~(8'd1 << y_ff[2:0]));
            r0 = grow({dcol_ff, dw_ff, dpg_ff, dh_ff}, px_col, y_ff[5:3]);
            {dcol_in, dw_in, dpg_in, dh_in} = r0;
            state_in = S_DONE;
         end
         S_RDOUT: begin
            rb_in = rdata; rbit_in = rdata[y_ff[2:0]];
            state_in = S_DONE;
         end
         // fill sweep
         S_FILL: begin
            mreq = '{we: 1'b1, addr: addr_type'(cnt_ff), wdata: {8{col_ff}}};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AddrBits+1)'(StoreBytes - 1)) begin
               ccol_in = '0; cpage_in = '0;
               dcol_in = '0; dw_in = 8'(ScreenWidth);
               dpg_in = '0; dh_in = 4'(PageCount);
               state_in = S_DONE;
            end
         end
         // scroll: read the byte one page below, then write it here; the last page is written zero
         S_SCRRD: begin
            mreq.addr = addr_type'(cnt_ff + (AddrBits+1)'(ScreenWidth));
            state_in = S_SCRWR;
            if (cnt_ff >= (AddrBits+1)'(StoreBytes - ScreenWidth)) begin
               mreq.we = 1'b1; mreq.addr = addr_type'(cnt_ff); mreq.wdata = '0;
               cnt_in = cnt_ff + 1'b1; state_in = S_SCRRD;
               if (cnt_ff == (AddrBits+1)'(StoreBytes - 1)) begin
                  dcol_in = '0; dw_in = 8'(ScreenWidth);
                  dpg_in = '0; dh_in = 4'(PageCount);
                  scr_in = 1'b1; state_in = S_DONE;
               end
            end
         end
         S_SCRWR: begin
            mreq = '{we: 1'b1, addr: addr_type'(cnt_ff), wdata: rdata};
            cnt_in = cnt_ff + 1'b1; state_in = S_SCRRD;
         end
         // present result
         S_DONE: begin
            vld_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; cnt_ff <= '0;
         ccol_ff <= '0; cpage_ff <= '0;
         dcol_ff <= '0; dw_ff <= '0; dpg_ff <= '0; dh_ff <= '0;
         inv_ff <= 1'b0; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in;
         ccol_ff <= ccol_in; cpage_ff <= cpage_in;
         dcol_ff <= dcol_in; dw_ff <= dw_in; dpg_ff <= dpg_in; dh_ff <= dh_in;
         inv_ff <= inv_in; vld_ff <= vld_in;
      end
      scr_ff <= scr_in; rb_ff <= rb_in; rbit_ff <= rbit_in;
      act_ff <= act_in; gidx_ff <= gidx_in; x_ff <= x_in; y_ff <= y_in; col_ff <= col_in;
   end

   assign rsp_valid            = vld_ff;
   assign rsp_read_byte        = rb_ff;
   assign rsp_pixel_bit        = rbit_ff;
   assign rsp_cursor_col       = ccol_ff;
   assign rsp_cursor_row       = cpage_ff;
   assign rsp_dirty_col_start  = dcol_ff;
   assign rsp_dirty_width      = dw_ff;
   assign rsp_dirty_page_start = dpg_ff;
   assign rsp_dirty_pages      = dh_ff;
   assign rsp_scrolled         = scr_ff;

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      ccol_ff < 5'(TextCols)) else $error("cursor column out of range");
   a_dirty_width: assert property (@(posedge clock) disable iff (reset)
      dw_ff <= 8'(ScreenWidth)) else $error("dirty width too large");
`endif
endmodule
